// ===== rtl/vnorm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared types and constants of the vector normalize unit.
// ----------------------------------------------------------------------------
package vnorm_pkg;

  // Width and reset value of the minimum length register.
  localparam int MIN_LEN_W = 16;
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 16'd1;

  // Control that travels beside the data from stage to stage.
  typedef struct packed {
    logic vld;
  } stage_ctl_t;

endpackage

// ===== rtl/vector_normalize_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_normalize_unit
// Length and unit vector of a 3D fixed-point vector, fully pipelined.
// ----------------------------------------------------------------------------
// The unit takes one vector per clock and gives one result per clock as long as
// the receiver takes them. A result passes the front stages, which form the sum
// of squares, then one stage per result bit, which runs the square root and the
// three quotients side by side, then one output register. Behind a waiting
// result one skid entry takes the next finished result; once it is full the
// input stalls until the receiver takes a result, and it opens again once the
// skid entry has moved into the output register. The unit vector is each
// component over the exact length, truncated toward zero; it is zero and
// too_short is set when the truncated length is below min_length.
module vector_normalize_unit #(
  parameter int COMP_WIDTH     = 32,
  parameter int UNIT_FRAC_BITS = 30
) (
  input  logic clk,
  input  logic rst,
  // Input: comp_x, comp_y, comp_z from the lowest bit up.
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((3*COMP_WIDTH+7)/8)*8-1:0]      s_tdata,
  // Output: unit_x, unit_y, unit_z, magnitude from the lowest bit up.
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((3*(UNIT_FRAC_BITS+2)+COMP_WIDTH+7)/8)*8-1:0] m_tdata,
  // Output: too_short.
  output logic                                   m_tuser,
  // Configuration: min_length.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [vnorm_pkg::MIN_LEN_W-1:0]        cfg_data
);

  localparam int CW    = COMP_WIDTH;
  localparam int F     = UNIT_FRAC_BITS;
  localparam int UW    = F + 2;
  localparam int SW    = 2*CW;
  localparam int PW    = F + 2*CW + 1;
  localparam int RW    = 2*CW + 2*F;
  localparam int NS    = (CW > F + 1) ? CW : F + 1;
  localparam int OUT_W = ((3*UW + CW + 7)/8)*8;
  localparam int RES_W = 3*UW + CW + 1;

  logic                              en;
  logic [vnorm_pkg::MIN_LEN_W-1:0]   min_length;
  logic [2:0][CW-1:0]                comp;

  vnorm_pkg::stage_ctl_t             ctl_in;
  vnorm_pkg::stage_ctl_t             ctl   [NS+1];
  logic [SW-1:0]                     sum   [NS+1];
  logic [2:0]                        neg   [NS+1];
  logic [CW-1:0]                     root  [NS+1];
  logic [SW-1:0]                     rrem  [NS+1];
  logic [2:0][F:0]                   quot  [NS+1];
  logic [2:0][PW-1:0]                prod  [NS+1];
  logic [2:0][RW-1:0]                res   [NS+1];

  logic                              short_flag;
  logic [2:0][UW-1:0]                unit;
  logic [RES_W-1:0]                  result;
  logic [RES_W-1:0]                  out_data, skid_data;
  logic                              out_vld, skid_vld;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= vnorm_pkg::MIN_LEN_RESET;
    end else if (cfg_valid) begin
      min_length <= cfg_data;
    end
  end

  // The pipeline moves whenever the skid entry is free.
  assign en       = ~skid_vld;
  assign s_tready = en;

  assign comp = {s_tdata[3*CW-1:2*CW], s_tdata[2*CW-1:CW], s_tdata[CW-1:0]};
  assign ctl_in.vld = s_tvalid;

  // Sum of squares.
  vnorm_front #(.CW(CW), .F(F)) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .ctl_in  (ctl_in),
    .comp    (comp),
    .ctl_out (ctl[0]),
    .sum     (sum[0]),
    .neg     (neg[0]),
    .res     (res[0])
  );

  assign root[0] = '0;
  assign rrem[0] = sum[0];
  assign quot[0] = '0;
  assign prod[0] = '0;

  // Bit stages of the root and the quotients.
  generate
    for (genvar k = 0; k < NS; k++) begin : g_stage
      vnorm_stage #(.CW(CW), .F(F), .K(k)) u_stage (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .ctl_in   (ctl[k]),
        .sum_in   (sum[k]),
        .neg_in   (neg[k]),
        .root_in  (root[k]),
        .rrem_in  (rrem[k]),
        .q_in     (quot[k]),
        .prod_in  (prod[k]),
        .res_in   (res[k]),
        .ctl_out  (ctl[k+1]),
        .sum_out  (sum[k+1]),
        .neg_out  (neg[k+1]),
        .root_out (root[k+1]),
        .rrem_out (rrem[k+1]),
        .q_out    (quot[k+1]),
        .prod_out (prod[k+1]),
        .res_out  (res[k+1])
      );
    end
  endgenerate

  // Threshold, zero handling and sign of the unit components.
  always_comb begin
    short_flag = root[NS] < CW'(min_length);
    for (int j = 0; j < 3; j++) begin
      if (short_flag || (sum[NS] == '0)) begin
        unit[j] = '0;
      end else if (neg[NS][j]) begin
        unit[j] = ~UW'(quot[NS][j]) + UW'(1);
      end else begin
        unit[j] = UW'(quot[NS][j]);
      end
    end
    result = {short_flag, root[NS], unit[2], unit[1], unit[0]};
  end

  // Output register with one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!out_vld || m_tready) begin
      if (skid_vld) begin
        out_vld  <= 1'b1;
        skid_vld <= 1'b0;
      end else begin
        out_vld  <= ctl[NS].vld;
      end
    end else if (ctl[NS].vld && en) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld || m_tready) begin
      out_data <= skid_vld ? skid_data : result;
    end else if (en) begin
      skid_data <= result;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = OUT_W'(out_data[RES_W-2:0]);
  assign m_tuser  = out_data[RES_W-1];

  // The skid entry only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld) else $error("skid entry valid with empty output");

  // A too-short result carries a zero unit vector.
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[3*UW-1:0] == '0))
    else $error("too-short result with nonzero unit vector");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_data)))
    else $error("stalled result changed");

  // Input is never taken while the skid entry is full.
  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> !s_tready) else $error("input taken with full skid entry");

endmodule

// ===== rtl/vnorm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnorm_front
// Three register stages: magnitude and sign of each component, the squares,
// then the sum of squares and the starting remainders of the quotient stages.
// ----------------------------------------------------------------------------
module vnorm_front #(
  parameter int CW = 32,
  parameter int F  = 30
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  vnorm_pkg::stage_ctl_t             ctl_in,
  input  logic [2:0][CW-1:0]                comp,
  output vnorm_pkg::stage_ctl_t             ctl_out,
  output logic [2*CW-1:0]                   sum,
  output logic [2:0]                        neg,
  output logic [2:0][2*CW+2*F-1:0]          res
);

  localparam int RW = 2*CW + 2*F;
  localparam int SW = 2*CW;

  vnorm_pkg::stage_ctl_t ctl_a, ctl_b;
  logic [2:0][CW-1:0]   mag_a;
  logic [2:0]           neg_a, neg_b;
  logic [2:0][2*CW-1:0] sq_b;
  logic [2:0][CW-1:0]   mag_next;

  // Magnitude of each component; the most negative value comes out exact.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag_next[j] = comp[j][CW-1] ? (~comp[j] + CW'(1)) : comp[j];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a   <= '0;
      ctl_b   <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl_a   <= ctl_in;
      ctl_b   <= ctl_a;
      ctl_out <= ctl_b;
    end
  end

  // Data stages.
  always_ff @(posedge clk) begin
    if (en) begin
      mag_a <= mag_next;
      neg_a <= {comp[2][CW-1], comp[1][CW-1], comp[0][CW-1]};
      for (int j = 0; j < 3; j++) begin
        sq_b[j] <= SW'(mag_a[j]) * SW'(mag_a[j]);
      end
      neg_b <= neg_a;
      sum   <= sq_b[0] + sq_b[1] + sq_b[2];
      neg   <= neg_b;
      for (int j = 0; j < 3; j++) begin
        res[j] <= RW'(sq_b[j]) << (2*F);
      end
    end
  end

endmodule

// ===== rtl/vnorm_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnorm_stage
// One bit step of the pipelined square root and of the three unit quotients.
// Each quotient is the largest q with q*q*sum <= a*a*2^(2F), built one bit a
// stage from a remainder and the running product q*sum.
// ----------------------------------------------------------------------------
module vnorm_stage #(
  parameter int CW = 32,
  parameter int F  = 30,
  parameter int K  = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  vnorm_pkg::stage_ctl_t      ctl_in,
  input  logic [2*CW-1:0]            sum_in,
  input  logic [2:0]                 neg_in,
  input  logic [CW-1:0]              root_in,
  input  logic [2*CW-1:0]            rrem_in,
  input  logic [2:0][F:0]            q_in,
  input  logic [2:0][F+2*CW:0]       prod_in,
  input  logic [2:0][2*CW+2*F-1:0]   res_in,
  output vnorm_pkg::stage_ctl_t      ctl_out,
  output logic [2*CW-1:0]            sum_out,
  output logic [2:0]                 neg_out,
  output logic [CW-1:0]              root_out,
  output logic [2*CW-1:0]            rrem_out,
  output logic [2:0][F:0]            q_out,
  output logic [2:0][F+2*CW:0]       prod_out,
  output logic [2:0][2*CW+2*F-1:0]   res_out
);

  localparam int SW = 2*CW;
  localparam int PW = F + 2*CW + 1;
  localparam int RW = 2*CW + 2*F;
  localparam int TW = RW + 2;

  logic [CW-1:0]           root_next;
  logic [SW-1:0]           rrem_next;
  logic [2:0][F:0]         q_next;
  logic [2:0][PW-1:0]      prod_next;
  logic [2:0][RW-1:0]      res_next;

  // Square root bit of this stage.
  generate
    if (K < CW) begin : g_root
      localparam int SB = CW - 1 - K;
      logic [SW:0] trial;
      always_comb begin
        trial     = ((SW+1)'(root_in) << (SB+1)) + ((SW+1)'(1) << (2*SB));
        root_next = root_in;
        rrem_next = rrem_in;
        if ({1'b0, rrem_in} >= trial) begin
          rrem_next      = rrem_in - trial[SW-1:0];
          root_next[SB]  = 1'b1;
        end
      end
    end else begin : g_root_pass
      always_comb begin
        root_next = root_in;
        rrem_next = rrem_in;
      end
    end
  endgenerate

  // Quotient bit of this stage for each component.
  generate
    if (K <= F) begin : g_quot
      localparam int QB = F - K;
      logic [2:0][TW-1:0] trial;
      always_comb begin
        for (int j = 0; j < 3; j++) begin
          trial[j]     = (TW'(prod_in[j]) << (QB+1)) + (TW'(sum_in) << (2*QB));
          q_next[j]    = q_in[j];
          prod_next[j] = prod_in[j];
          res_next[j]  = res_in[j];
          if (TW'(res_in[j]) >= trial[j]) begin
            res_next[j]   = res_in[j] - trial[j][RW-1:0];
            prod_next[j]  = prod_in[j] + (PW'(sum_in) << QB);
            q_next[j][QB] = 1'b1;
          end
        end
      end
    end else begin : g_quot_pass
      always_comb begin
        q_next    = q_in;
        prod_next = prod_in;
        res_next  = res_in;
      end
    end
  endgenerate

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (en) begin
      sum_out  <= sum_in;
      neg_out  <= neg_in;
      root_out <= root_next;
      rrem_out <= rrem_next;
      q_out    <= q_next;
      prod_out <= prod_next;
      res_out  <= res_next;
    end
  end

endmodule
